>>> src/bscs_pkg.sv
package bscs_pkg;

   // rectangle dimension width and derived datapath widths
   localparam int DIM_W  = 13;
   localparam int FRAC_W = 12;
   localparam int NUM_W  = DIM_W + FRAC_W;
   localparam int STEP_W = 14;
   localparam int DIV_STAGES = NUM_W;

   // source pixel format codes
   localparam logic [2:0] SRC_GRAY   = 3'd0;
   localparam logic [2:0] SRC_RGB565 = 3'd1;
   localparam logic [2:0] SRC_YUV    = 3'd2;
   localparam logic [2:0] SRC_YVU    = 3'd3;

   // destination pixel format codes
   localparam logic [1:0] DST_GRAY   = 2'd0;
   localparam logic [1:0] DST_RGB565 = 2'd1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   // quotient thresholds for the decimation choice
   localparam logic [NUM_W-1:0] F_SAT = NUM_W'(16) << FRAC_W;
   localparam logic [NUM_W-1:0] F_X8  = NUM_W'(8) << FRAC_W;
   localparam logic [NUM_W-1:0] F_X4  = NUM_W'(4) << FRAC_W;
   localparam logic [NUM_W-1:0] F_X2  = NUM_W'(2) << FRAC_W;

   localparam logic [STEP_W-1:0] STEP_SAT = STEP_W'(14'h2000);
   localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(1);

   localparam logic [1:0] DEC_1 = 2'd0;
   localparam logic [1:0] DEC_2 = 2'd1;
   localparam logic [1:0] DEC_4 = 2'd2;
   localparam logic [1:0] DEC_8 = 2'd3;

   typedef enum logic [3:0] {
      REASON_OK          = 4'd0,
      REASON_SRC_FMT     = 4'd1,
      REASON_DST_FMT     = 4'd2,
      REASON_GRAY_RGB    = 4'd3,
      REASON_NOT_X8      = 4'd4,
      REASON_BLEND       = 4'd5,
      REASON_TRANSFORM   = 4'd6,
      REASON_SHRINK      = 4'd7,
      REASON_ENLARGE     = 4'd8,
      REASON_FLIP_SCALED = 4'd9,
      REASON_ZERO_SIZE   = 4'd10
   } reason_type;

   // request check outcome, travels alongside the divider lanes
   typedef struct packed {
      reason_type reason;
      logic       block_16;
      logic       swap;
      logic       convert;
   } check_type;

   // per-axis scaler settings
   typedef struct packed {
      logic [1:0]        dec;
      logic [STEP_W-1:0] step;
   } axis_type;

endpackage

>>> src/bscs_check.sv
module bscs_check (
   input  logic [bscs_pkg::DIM_W-1:0] src_width,
   input  logic [bscs_pkg::DIM_W-1:0] src_height,
   input  logic [bscs_pkg::DIM_W-1:0] dst_width,
   input  logic [bscs_pkg::DIM_W-1:0] dst_height,
   input  logic [2:0]                 src_format,
   input  logic [1:0]                 dst_format,
   input  logic [7:0]                 alpha,
   input  logic                       has_color_palette,
   input  logic                       has_alpha_palette,
   input  logic                       has_transform,
   input  logic                       mirror_h,
   input  logic                       flip_v,
   output bscs_pkg::check_type        check
);

   logic not_x8;
   logic blend;
   logic shrink;
   logic enlarge;
   logic flip_scaled;
   logic zero_size;

   // individual rules
   always_comb begin
      not_x8 = (|src_width[2:0]) | (|src_height[2:0]) |
               (|dst_width[2:0]) | (|dst_height[2:0]);
      blend = (alpha != bscs_pkg::ALPHA_OPAQUE) | has_color_palette | has_alpha_palette;
      shrink = (dst_width < (src_width >> 4)) | (dst_height < (src_height >> 4));
      enlarge = ({{bscs_pkg::FRAC_W{1'b0}}, dst_width} >
                 {src_width, {bscs_pkg::FRAC_W{1'b0}}}) |
                ({{bscs_pkg::FRAC_W{1'b0}}, dst_height} >
                 {src_height, {bscs_pkg::FRAC_W{1'b0}}});
      flip_scaled = (mirror_h | flip_v) &
                    ((src_width != dst_width) | (src_height != dst_height));
      zero_size = (src_width == '0) | (src_height == '0) |
                  (dst_width == '0) | (dst_height == '0);
   end

   // first failing rule wins
   always_comb begin
      if (src_format > bscs_pkg::SRC_YVU) begin
         check.reason = bscs_pkg::REASON_SRC_FMT;
      end else if (dst_format > bscs_pkg::DST_RGB565) begin
         check.reason = bscs_pkg::REASON_DST_FMT;
      end else if (dst_format == bscs_pkg::DST_GRAY && src_format == bscs_pkg::SRC_RGB565) begin
         check.reason = bscs_pkg::REASON_GRAY_RGB;
      end else if (not_x8) begin
         check.reason = bscs_pkg::REASON_NOT_X8;
      end else if (blend) begin
         check.reason = bscs_pkg::REASON_BLEND;
      end else if (has_transform) begin
         check.reason = bscs_pkg::REASON_TRANSFORM;
      end else if (shrink) begin
         check.reason = bscs_pkg::REASON_SHRINK;
      end else if (enlarge) begin
         check.reason = bscs_pkg::REASON_ENLARGE;
      end else if (flip_scaled) begin
         check.reason = bscs_pkg::REASON_FLIP_SCALED;
      end else if (zero_size) begin
         check.reason = bscs_pkg::REASON_ZERO_SIZE;
      end else begin
         check.reason = bscs_pkg::REASON_OK;
      end
      check.block_16 = ~((|src_width[3:0]) | (|src_height[3:0]) |
                         (|dst_width[3:0]) | (|dst_height[3:0]));
      check.swap = (src_format == bscs_pkg::SRC_YUV) | (src_format == bscs_pkg::SRC_YVU);
      check.convert = (dst_format == bscs_pkg::DST_RGB565) &
                      (src_format != bscs_pkg::SRC_RGB565);
   end

endmodule

>>> src/bscs_axis_lane.sv
module bscs_axis_lane (
   input  logic                              clock,
   input  logic [bscs_pkg::DIM_W-1:0]        dim_src,
   input  logic [bscs_pkg::DIM_W-1:0]        dim_dst,
   input  logic [bscs_pkg::DIV_STAGES:0]     adv,
   output bscs_pkg::axis_type                result
);

   localparam int NQ = bscs_pkg::DIV_STAGES;

   logic [bscs_pkg::NUM_W-1:0] nq_ff  [0:NQ];
   logic                       up_ff  [0:NQ];
   logic [bscs_pkg::DIM_W-1:0] den_ff [0:NQ-1];
   logic [bscs_pkg::DIM_W-1:0] rem_ff [1:NQ-1];

   logic                       up_in;
   logic [bscs_pkg::NUM_W-1:0] num_in;
   logic [bscs_pkg::DIM_W-1:0] den_in;

   // operand set-up: enlarge uses (in-1)/(out-1), otherwise in/out
   always_comb begin
      up_in = dim_dst > dim_src;
      if (up_in) begin
         num_in = {dim_src - bscs_pkg::DIM_W'(1), {bscs_pkg::FRAC_W{1'b0}}};
         den_in = dim_dst - bscs_pkg::DIM_W'(1);
      end else begin
         num_in = {dim_src, {bscs_pkg::FRAC_W{1'b0}}};
         den_in = dim_dst;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         nq_ff[0]  <= num_in;
         den_ff[0] <= den_in;
         up_ff[0]  <= up_in;
      end
   end

   // restoring division, one quotient bit per stage; quotient bits shift in
   // at the bottom as numerator bits leave at the top
   for (genvar k = 1; k <= NQ; k++) begin : g_step
      logic [bscs_pkg::DIM_W-1:0] rem_prev;
      logic [bscs_pkg::DIM_W:0]   trial;
      logic [bscs_pkg::DIM_W:0]   diff;
      logic                       ge;
      logic [bscs_pkg::NUM_W-1:0] nq_in;

      if (k == 1) begin : g_first
         assign rem_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
      end

      always_comb begin
         trial = {rem_prev, nq_ff[k-1][bscs_pkg::NUM_W-1]};
         diff  = trial - {1'b0, den_ff[k-1]};
         ge    = trial >= {1'b0, den_ff[k-1]};
         nq_in = {nq_ff[k-1][bscs_pkg::NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            nq_ff[k] <= nq_in;
            up_ff[k] <= up_ff[k-1];
         end
      end

      if (k < NQ) begin : g_carry
         logic [bscs_pkg::DIM_W-1:0] rem_in;
         assign rem_in = ge ? diff[bscs_pkg::DIM_W-1:0] : trial[bscs_pkg::DIM_W-1:0];
         always_ff @(posedge clock) begin
            if (adv[k]) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   logic [bscs_pkg::NUM_W-1:0] quo;
   logic [bscs_pkg::NUM_W-1:0] shifted;
   logic [1:0]                 dec;

   // decimation choice and step from the finished quotient
   always_comb begin
      quo = nq_ff[NQ];
      if (quo > bscs_pkg::F_X8) begin
         dec = bscs_pkg::DEC_8;
      end else if (quo > bscs_pkg::F_X4) begin
         dec = bscs_pkg::DEC_4;
      end else if (quo > bscs_pkg::F_X2) begin
         dec = bscs_pkg::DEC_2;
      end else begin
         dec = bscs_pkg::DEC_1;
      end
      case (dec)
         bscs_pkg::DEC_8: shifted = quo >> 3;
         bscs_pkg::DEC_4: shifted = quo >> 2;
         bscs_pkg::DEC_2: shifted = quo >> 1;
         default:         shifted = quo;
      endcase
      if (up_ff[NQ]) begin
         result.dec  = bscs_pkg::DEC_1;
         result.step = quo[bscs_pkg::STEP_W-1:0];
      end else if (quo >= bscs_pkg::F_SAT) begin
         result.dec  = bscs_pkg::DEC_8;
         result.step = bscs_pkg::STEP_SAT;
      end else begin
         result.dec  = dec;
         result.step = (shifted == '0) ? bscs_pkg::STEP_MIN
                                       : shifted[bscs_pkg::STEP_W-1:0];
      end
   end

endmodule

>>> src/bscs_merge.sv
module bscs_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fin_valid,
   input  bscs_pkg::check_type           fin_check,
   input  bscs_pkg::axis_type            fin_x,
   input  bscs_pkg::axis_type            fin_y,
   output logic                          out_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [3:0]                    rsp_reject_reason,
   output logic                          rsp_block_is_16,
   output logic [1:0]                    rsp_dec_x,
   output logic [1:0]                    rsp_dec_y,
   output logic [bscs_pkg::STEP_W-1:0]   rsp_scale_x,
   output logic [bscs_pkg::STEP_W-1:0]   rsp_scale_y,
   output logic                          rsp_swap_bytes,
   output logic                          rsp_color_convert
);

   logic                        rsp_valid_ff;
   logic                        ok_ff;
   logic [3:0]                  reason_ff;
   logic                        block_ff;
   logic [1:0]                  dec_x_ff;
   logic [1:0]                  dec_y_ff;
   logic [bscs_pkg::STEP_W-1:0] scale_x_ff;
   logic [bscs_pkg::STEP_W-1:0] scale_y_ff;
   logic                        swap_ff;
   logic                        conv_ff;

   logic                        ok_in;

   assign out_ready = ~rsp_valid_ff | rsp_ready;
   assign ok_in     = (fin_check.reason == bscs_pkg::REASON_OK);

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   // combine lanes and check result; settings cleared on reject
   always_ff @(posedge clock) begin
      if (out_ready && fin_valid) begin
         ok_ff      <= ok_in;
         reason_ff  <= fin_check.reason;
         block_ff   <= ok_in & fin_check.block_16;
         dec_x_ff   <= ok_in ? fin_x.dec : 2'd0;
         dec_y_ff   <= ok_in ? fin_y.dec : 2'd0;
         scale_x_ff <= ok_in ? fin_x.step : '0;
         scale_y_ff <= ok_in ? fin_y.step : '0;
         swap_ff    <= ok_in & fin_check.swap;
         conv_ff    <= ok_in & fin_check.convert;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = ok_ff;
   assign rsp_reject_reason = reason_ff;
   assign rsp_block_is_16   = block_ff;
   assign rsp_dec_x         = dec_x_ff;
   assign rsp_dec_y         = dec_y_ff;
   assign rsp_scale_x       = scale_x_ff;
   assign rsp_scale_y       = scale_y_ff;
   assign rsp_swap_bytes    = swap_ff;
   assign rsp_color_convert = conv_ff;

`ifndef SYNTHESIS
   // accept flag agrees with the reason code
   a_accept_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (ok_ff == (reason_ff == bscs_pkg::REASON_OK)))
      else $error("accept flag disagrees with reject reason");

   // rejected transaction carries no engine settings
   a_reject_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ok_ff) |-> (scale_x_ff == '0 && scale_y_ff == '0 &&
         dec_x_ff == 2'd0 && dec_y_ff == 2'd0 && !block_ff && !swap_ff && !conv_ff))
      else $error("rejected transaction has non-zero settings");

   // accepted steps lie in 1 .. 0x2000
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ok_ff) |-> (scale_x_ff != '0 && scale_x_ff <= bscs_pkg::STEP_SAT &&
         scale_y_ff != '0 && scale_y_ff <= bscs_pkg::STEP_SAT))
      else $error("scale step out of range");

   // a result entering the output register came out of the lanes
   a_load_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !fin_valid) |=> !rsp_valid_ff)
      else $error("result appeared without a finished transaction");
`endif

endmodule

>>> src/blit_request_check_and_scaler_setup_unit.sv
// Blit request checker and scaler setup. Each request transaction yields one
// response transaction: an accept flag with the first failing rule as reject
// reason, and for accepted requests the block size, per-axis decimation shift
// and 2.12 scale step, byte swap and colour conversion flags. One request is
// taken per clock cycle while req_ready is high. Each request passes through
// the two divider lanes (one per axis), each an operand stage and 25 radix-2
// divide stages, followed by the output register. Empty stages keep filling
// while a response waits, so the pipeline holds up to 27 requests in flight.
module blit_request_check_and_scaler_setup_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bscs_pkg::DIM_W-1:0]    req_src_width,
   input  logic [bscs_pkg::DIM_W-1:0]    req_src_height,
   input  logic [bscs_pkg::DIM_W-1:0]    req_dst_width,
   input  logic [bscs_pkg::DIM_W-1:0]    req_dst_height,
   input  logic [2:0]                    req_src_format,
   input  logic [1:0]                    req_dst_format,
   input  logic [7:0]                    req_alpha,
   input  logic                          req_has_color_palette,
   input  logic                          req_has_alpha_palette,
   input  logic                          req_has_transform,
   input  logic                          req_mirror_h,
   input  logic                          req_flip_v,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [3:0]                    rsp_reject_reason,
   output logic                          rsp_block_is_16,
   output logic [1:0]                    rsp_dec_x,
   output logic [1:0]                    rsp_dec_y,
   output logic [bscs_pkg::STEP_W-1:0]   rsp_scale_x,
   output logic [bscs_pkg::STEP_W-1:0]   rsp_scale_y,
   output logic                          rsp_swap_bytes,
   output logic                          rsp_color_convert
);

   localparam int NQ = bscs_pkg::DIV_STAGES;

   bscs_pkg::check_type check;
   bscs_pkg::check_type side_ff [0:NQ];
   bscs_pkg::axis_type  res_x;
   bscs_pkg::axis_type  res_y;

   logic [NQ:0] vld_ff;
   logic [NQ:0] vld_in;
   logic [NQ:0] stage_rdy;
   logic        out_ready;

   // request rules
   bscs_check u_check (
      .src_width         (req_src_width),
      .src_height        (req_src_height),
      .dst_width         (req_dst_width),
      .dst_height        (req_dst_height),
      .src_format        (req_src_format),
      .dst_format        (req_dst_format),
      .alpha             (req_alpha),
      .has_color_palette (req_has_color_palette),
      .has_alpha_palette (req_has_alpha_palette),
      .has_transform     (req_has_transform),
      .mirror_h          (req_mirror_h),
      .flip_v            (req_flip_v),
      .check             (check)
   );

   // a stage may load when it or some stage downstream has room
   for (genvar k = 0; k <= NQ; k++) begin : g_rdy
      assign stage_rdy[k] = out_ready | ~(&vld_ff[NQ:k]);
   end
   assign req_ready = stage_rdy[0];

   // stage valid bits
   always_comb begin
      vld_in[0] = stage_rdy[0] ? req_valid : vld_ff[0];
      for (int k = 1; k <= NQ; k++) begin
         vld_in[k] = stage_rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // check result rides along with the divider stages
   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         side_ff[0] <= check;
      end
      for (int k = 1; k <= NQ; k++) begin
         if (stage_rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // one divider lane per axis
   bscs_axis_lane u_lane_x (
      .clock   (clock),
      .dim_src (req_src_width),
      .dim_dst (req_dst_width),
      .adv     (stage_rdy),
      .result  (res_x)
   );

   bscs_axis_lane u_lane_y (
      .clock   (clock),
      .dim_src (req_src_height),
      .dim_dst (req_dst_height),
      .adv     (stage_rdy),
      .result  (res_y)
   );

   // merge and output register
   bscs_merge u_merge (
      .clock             (clock),
      .reset             (reset),
      .fin_valid         (vld_ff[NQ]),
      .fin_check         (side_ff[NQ]),
      .fin_x             (res_x),
      .fin_y             (res_y),
      .out_ready         (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_reject_reason (rsp_reject_reason),
      .rsp_block_is_16   (rsp_block_is_16),
      .rsp_dec_x         (rsp_dec_x),
      .rsp_dec_y         (rsp_dec_y),
      .rsp_scale_x       (rsp_scale_x),
      .rsp_scale_y       (rsp_scale_y),
      .rsp_swap_bytes    (rsp_swap_bytes),
      .rsp_color_convert (rsp_color_convert)
   );

endmodule

>>> sim/testbench.sv
module testbench;
   import bscs_pkg::*;

   localparam int STALL_LIMIT  = 4000;  // cycles with no transaction before giving up
   localparam int DRAIN_CYCLES = 40;    // pipeline latency plus margin
   localparam int RANDOM_ITEMS = 390;   // per idling phase

   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
      logic [2:0]       src_format;
      logic [1:0]       dst_format;
      logic [7:0]       alpha;
      logic             has_color_palette;
      logic             has_alpha_palette;
      logic             has_transform;
      logic             mirror_h;
      logic             flip_v;
   } blit_request_type;

   typedef struct packed {
      logic              accepted;
      reason_type        reason;
      logic              block_is_16;
      logic [1:0]        dec_x;
      logic [1:0]        dec_y;
      logic [STEP_W-1:0] scale_x;
      logic [STEP_W-1:0] scale_y;
      logic              swap_bytes;
      logic              color_convert;
   } blit_setup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [DIM_W-1:0] req_src_width = '0;
   logic [DIM_W-1:0] req_src_height = '0;
   logic [DIM_W-1:0] req_dst_width = '0;
   logic [DIM_W-1:0] req_dst_height = '0;
   logic [2:0]       req_src_format = '0;
   logic [1:0]       req_dst_format = '0;
   logic [7:0]       req_alpha = '0;
   logic             req_has_color_palette = 1'b0;
   logic             req_has_alpha_palette = 1'b0;
   logic             req_has_transform = 1'b0;
   logic             req_mirror_h = 1'b0;
   logic             req_flip_v = 1'b0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_accepted;
   logic [3:0]        rsp_reject_reason;
   logic              rsp_block_is_16;
   logic [1:0]        rsp_dec_x;
   logic [1:0]        rsp_dec_y;
   logic [STEP_W-1:0] rsp_scale_x;
   logic [STEP_W-1:0] rsp_scale_y;
   logic              rsp_swap_bytes;
   logic              rsp_color_convert;

   blit_setup_type pending_setups[$];
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int mismatch_count    = 0;
   int quiet_cycles      = 0;

   blit_request_check_and_scaler_setup_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_src_width         (req_src_width),
      .req_src_height        (req_src_height),
      .req_dst_width         (req_dst_width),
      .req_dst_height        (req_dst_height),
      .req_src_format        (req_src_format),
      .req_dst_format        (req_dst_format),
      .req_alpha             (req_alpha),
      .req_has_color_palette (req_has_color_palette),
      .req_has_alpha_palette (req_has_alpha_palette),
      .req_has_transform     (req_has_transform),
      .req_mirror_h          (req_mirror_h),
      .req_flip_v            (req_flip_v),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_reject_reason     (rsp_reject_reason),
      .rsp_block_is_16       (rsp_block_is_16),
      .rsp_dec_x             (rsp_dec_x),
      .rsp_dec_y             (rsp_dec_y),
      .rsp_scale_x           (rsp_scale_x),
      .rsp_scale_y           (rsp_scale_y),
      .rsp_swap_bytes        (rsp_swap_bytes),
      .rsp_color_convert     (rsp_color_convert)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // one axis of the scaler: decimation shift and 2.12 step
   function automatic void scale_axis(input int unsigned src, input int unsigned dst,
                                      output logic [1:0] dec, output logic [STEP_W-1:0] step);
      int unsigned ratio;
      if (dst > src) begin
         dec  = DEC_1;
         step = STEP_W'((dst > 1) ? (((src - 1) << FRAC_W) / (dst - 1)) : (1 << FRAC_W));
      end else begin
         ratio = (src << FRAC_W) / dst;
         if (ratio >= F_SAT) begin
            dec  = DEC_8;
            step = STEP_SAT;
         end else begin
            if (ratio > F_X8)
               dec = DEC_8;
            else if (ratio > F_X4)
               dec = DEC_4;
            else if (ratio > F_X2)
               dec = DEC_2;
            else
               dec = DEC_1;
            ratio = ratio >> dec;
            step  = (ratio == 0) ? STEP_MIN : STEP_W'(ratio);
         end
      end
   endfunction

   function automatic blit_setup_type predict_setup(blit_request_type r);
      blit_setup_type s;
      int unsigned sw, sh, dw, dh;
      logic        flips;
      sw    = r.src_width;
      sh    = r.src_height;
      dw    = r.dst_width;
      dh    = r.dst_height;
      flips = r.mirror_h | r.flip_v;
      s     = '0;
      // rules in priority order, first failure wins
      if (r.src_format > SRC_YVU)
         s.reason = REASON_SRC_FMT;
      else if (r.dst_format > DST_RGB565)
         s.reason = REASON_DST_FMT;
      else if (r.dst_format == DST_GRAY && r.src_format == SRC_RGB565)
         s.reason = REASON_GRAY_RGB;
      else if (((sw | sh | dw | dh) & 7) != 0)
         s.reason = REASON_NOT_X8;
      else if (r.alpha != ALPHA_OPAQUE || r.has_color_palette || r.has_alpha_palette)
         s.reason = REASON_BLEND;
      else if (r.has_transform)
         s.reason = REASON_TRANSFORM;
      else if (dw < sw / 16 || dh < sh / 16)
         s.reason = REASON_SHRINK;
      else if (dw > sw * 4096 || dh > sh * 4096)
         s.reason = REASON_ENLARGE;
      else if (flips && (sw != dw || sh != dh))
         s.reason = REASON_FLIP_SCALED;
      else if (sw == 0 || sh == 0 || dw == 0 || dh == 0)
         s.reason = REASON_ZERO_SIZE;
      else
         s.reason = REASON_OK;
      if (s.reason == REASON_OK) begin
         s.accepted    = 1'b1;
         s.block_is_16 = (((sw | sh | dw | dh) & 15) == 0);
         scale_axis(sw, dw, s.dec_x, s.scale_x);
         scale_axis(sh, dh, s.dec_y, s.scale_y);
         s.swap_bytes    = (r.src_format == SRC_YUV || r.src_format == SRC_YVU);
         s.color_convert = (r.dst_format == DST_RGB565 && r.src_format != SRC_RGB565);
      end
      return s;
   endfunction

   function automatic string show_setup(blit_setup_type s);
      return $sformatf("acc=%0d rsn=%0d blk16=%0d dec=%0d/%0d step=%h/%h swap=%0d cnv=%0d",
                       s.accepted, s.reason, s.block_is_16, s.dec_x, s.dec_y,
                       s.scale_x, s.scale_y, s.swap_bytes, s.color_convert);
   endfunction

   // ---------------------------------------------------------------------
   // Request construction
   // ---------------------------------------------------------------------

   // well-formed request, opaque, no palettes, no transform
   function automatic blit_request_type plain_request(int unsigned sw, int unsigned sh,
                                                      int unsigned dw, int unsigned dh);
      blit_request_type r;
      r            = '0;
      r.src_width  = DIM_W'(sw);
      r.src_height = DIM_W'(sh);
      r.dst_width  = DIM_W'(dw);
      r.dst_height = DIM_W'(dh);
      r.src_format = SRC_YUV;
      r.dst_format = DST_RGB565;
      r.alpha      = ALPHA_OPAQUE;
      return r;
   endfunction

   // mostly small sizes, some across the full range
   function automatic int unsigned random_dim();
      if ($urandom_range(0, 1) == 0)
         return 8 * $urandom_range(1, 16);
      return 8 * $urandom_range(1, 1023);
   endfunction

   // destination size for a given source size, mostly within the scaling limits
   function automatic int unsigned partner_dim(int unsigned src);
      int unsigned lo;
      lo = ((src / 16 + 7) / 8) * 8;
      if (lo < 8)
         lo = 8;
      case ($urandom_range(0, 5))
         0: return src;
         1: return random_dim();
         2: return lo;
         3: return 8 * $urandom_range(lo / 8, src / 8);
         4: return 8 * $urandom_range(src / 8, 1023);
         default: return 8 * $urandom_range(1, 8);
      endcase
   endfunction

   function automatic blit_request_type random_request();
      blit_request_type r;
      int unsigned      sw, sh;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // pure noise over every bit
         r.src_width         = DIM_W'($urandom);
         r.src_height        = DIM_W'($urandom);
         r.dst_width         = DIM_W'($urandom);
         r.dst_height        = DIM_W'($urandom);
         r.src_format        = 3'($urandom);
         r.dst_format        = 2'($urandom);
         r.alpha             = 8'($urandom);
         r.has_color_palette = 1'($urandom);
         r.has_alpha_palette = 1'($urandom);
         r.has_transform     = 1'($urandom);
         r.mirror_h          = 1'($urandom);
         r.flip_v            = 1'($urandom);
         return r;
      end
      sw = random_dim();
      sh = random_dim();
      r  = plain_request(sw, sh, partner_dim(sw), partner_dim(sh));
      r.src_format = 3'($urandom_range(0, 3));
      r.dst_format = 2'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         // flips, mostly on unscaled copies
         r.mirror_h = 1'($urandom);
         r.flip_v   = ~r.mirror_h | 1'($urandom);
         if ($urandom_range(0, 9) < 7) begin
            r.dst_width  = r.src_width;
            r.dst_height = r.src_height;
         end
      end
      if (pick < 30) begin
         // one broken field on an otherwise sane request
         case ($urandom_range(0, 9))
            0: r.alpha = 8'($urandom_range(0, 254));
            1: r.has_color_palette = 1'b1;
            2: r.has_alpha_palette = 1'b1;
            3: r.has_transform = 1'b1;
            4: r.dst_height = r.dst_height | DIM_W'($urandom_range(1, 7));
            5: r.src_width = '0;
            6: r.src_format = 3'($urandom_range(4, 7));
            7: r.dst_format = 2'($urandom_range(2, 3));
            8: r.dst_width = DIM_W'(8 * $urandom_range(0, r.src_width / 128));
            default: r.dst_height = '0;
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving and checking
   // ---------------------------------------------------------------------

   // present one request transaction and wait until it is taken
   task automatic send_request(blit_request_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_src_width         = r.src_width;
      req_src_height        = r.src_height;
      req_dst_width         = r.dst_width;
      req_dst_height        = r.dst_height;
      req_src_format        = r.src_format;
      req_dst_format        = r.dst_format;
      req_alpha             = r.alpha;
      req_has_color_palette = r.has_color_palette;
      req_has_alpha_palette = r.has_alpha_palette;
      req_has_transform     = r.has_transform;
      req_mirror_h          = r.mirror_h;
      req_flip_v            = r.flip_v;
      req_valid             = 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_setups.push_back(predict_setup(r));
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait until every predicted response has been checked
   task automatic wait_drained();
      while (pending_setups.size() != 0)
         @(posedge clock);
   endtask

   // random back-pressure on the response side
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      blit_setup_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.accepted      = rsp_accepted;
         got.reason        = reason_type'(rsp_reject_reason);
         got.block_is_16   = rsp_block_is_16;
         got.dec_x         = rsp_dec_x;
         got.dec_y         = rsp_dec_y;
         got.scale_x       = rsp_scale_x;
         got.scale_y       = rsp_scale_y;
         got.swap_bytes    = rsp_swap_bytes;
         got.color_convert = rsp_color_convert;
         if (pending_setups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: %s", show_setup(got));
         end else begin
            want = pending_setups.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %s\n          actual   %s",
                           show_setup(want), show_setup(got));
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // at least one request per reject rule, including unused format codes and zero sizes
   task automatic test_reject_rules();
      blit_request_type r;
      r = plain_request(64, 64, 64, 64); r.src_format = 3'd4;      send_request(r);
      r = plain_request(64, 64, 64, 64); r.src_format = 3'd7;      send_request(r);
      r = plain_request(64, 64, 64, 64); r.dst_format = 2'd2;      send_request(r);
      r = plain_request(64, 64, 64, 64); r.dst_format = 2'd3;      send_request(r);
      r = plain_request(64, 64, 64, 64);
      r.src_format = SRC_RGB565; r.dst_format = DST_GRAY;          send_request(r);
      r = plain_request(8191, 8191, 8191, 8191);                   send_request(r);
      r = plain_request(64, 64, 64, 64); r.alpha = 8'd0;           send_request(r);
      r = plain_request(64, 64, 64, 64); r.alpha = 8'd254;         send_request(r);
      r = plain_request(64, 64, 64, 64); r.has_color_palette = 1;  send_request(r);
      r = plain_request(64, 64, 64, 64); r.has_alpha_palette = 1;  send_request(r);
      r = plain_request(64, 64, 64, 64); r.has_transform = 1;      send_request(r);
      r = plain_request(8184, 64, 8, 64);                          send_request(r);
      r = plain_request(64, 0, 64, 8);                             send_request(r);
      r = plain_request(64, 64, 128, 64); r.mirror_h = 1;          send_request(r);
      r = plain_request(64, 64, 64, 32); r.flip_v = 1;             send_request(r);
      r = plain_request(0, 0, 0, 0);                               send_request(r);
      r = plain_request(8, 64, 0, 64);                             send_request(r);
   endtask

   // accepted requests at the scaling extremes and most valid format pairs
   task automatic test_scaler_extremes();
      blit_request_type r;
      r = plain_request(8184, 8184, 8184, 8184);
      r.mirror_h = 1; r.flip_v = 1;                                send_request(r);
      r = plain_request(8, 8, 8184, 8184); r.src_format = SRC_GRAY;
      r.dst_format = DST_GRAY;                                     send_request(r);
      r = plain_request(128, 136, 8, 8); r.src_format = SRC_RGB565; send_request(r);
      r = plain_request(8184, 8176, 512, 520); r.src_format = SRC_YVU;
      r.dst_format = DST_GRAY;                                     send_request(r);
      r = plain_request(32, 48, 16, 64); r.src_format = SRC_GRAY;  send_request(r);
      r = plain_request(64, 64, 32, 16);                           send_request(r);
      r = plain_request(64, 64, 8, 24); r.src_format = SRC_YVU;    send_request(r);
      r = plain_request(8, 8, 8, 8);                               send_request(r);
   endtask

   task automatic test_random_requests(int count);
      repeat (count)
         send_request(random_request());
   endtask

   // hold off the sender until the pipeline has emptied, then resume
   task automatic test_drain_pause();
      repeat (12)
         send_request(random_request());
      stop_requests();
      wait_drained();
      repeat (12)
         send_request(random_request());
   endtask

   initial begin
      sender_idle_pct   = 33;
      receiver_idle_pct = 48;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reject_rules();
      test_scaler_extremes();
      test_random_requests(RANDOM_ITEMS);
      test_drain_pause();

      sender_idle_pct   = 48;
      receiver_idle_pct = 33;
      test_random_requests(RANDOM_ITEMS);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_requests(RANDOM_ITEMS);
      stop_requests();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_setups.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
